>>> design/tsws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_pkg: shared types of the tagged stack with search
// Request and status codes, channel payloads, the command word that the
// controller broadcasts along the row of entry cells, and controller states.
// ----------------------------------------------------------------------------
package tsws_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REQ_PUSH   = 3'd0,
		REQ_POP    = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_SEARCH = 3'd3,
		REQ_DEDUP  = 3'd4
	} req_e;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_EMPTY     = 3'd1,
		STS_FULL      = 3'd2,
		STS_RANGE     = 3'd3,
		STS_NOT_FOUND = 3'd4
	} status_e;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_SHIFT_UP
	} cell_cmd_e;

	typedef enum logic {
		S_IDLE,
		S_DEDUP
	} ctrl_state_e;

	typedef struct packed {
		logic [2:0]               req_type;
		logic signed [DATA_W-1:0] push_value;
		logic signed [DATA_W-1:0] push_time;
		logic [3:0]               remove_position;
		logic signed [DATA_W-1:0] search_value;
	} req_t;

	typedef struct packed {
		logic [2:0]               status;
		logic signed [DATA_W-1:0] out_value;
		logic signed [DATA_W-1:0] out_time;
		logic [3:0]               found_position;
		logic [4:0]               entry_count;
	} rsp_t;

	// Command broadcast to every cell; the data enters the top cell on a push.
	typedef struct packed {
		cell_cmd_e         cmd;
		logic [DATA_W-1:0] val;
		logic [DATA_W-1:0] stamp;
	} cell_ctl_t;

endpackage

>>> design/tsws_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_req_if: request channel
// Valid/ready channel that carries one request item per transfer.
// ----------------------------------------------------------------------------
interface tsws_req_if;
	import tsws_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

>>> design/tsws_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_rsp_if: result channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface tsws_rsp_if;
	import tsws_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

>>> design/tsws_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_cell: one stack entry
// Holds the value and timestamp of one position, takes the entry above it on
// a push or the entry below it when a gap above closes, and compares its
// value with the broadcast key.
// ----------------------------------------------------------------------------
module tsws_cell #(
	parameter int CELL_IDX = 0,
	parameter int IDX_W    = 4
) (
	input  logic                                clk,
	input  tsws_pkg::cell_ctl_t                 ctl,
	input  logic [IDX_W-1:0]                    from,
	input  logic [tsws_pkg::DATA_W-1:0]         key,
	input  logic [tsws_pkg::DATA_W-1:0]         above_val,
	input  logic [tsws_pkg::DATA_W-1:0]         above_stamp,
	input  logic [tsws_pkg::DATA_W-1:0]         below_val,
	input  logic [tsws_pkg::DATA_W-1:0]         below_stamp,
	output logic [tsws_pkg::DATA_W-1:0]         val,
	output logic [tsws_pkg::DATA_W-1:0]         stamp,
	output logic                                hit
);
	import tsws_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] stamp_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_PUSH: begin
				val_q   <= above_val;
				stamp_q <= above_stamp;
			end
			CMD_SHIFT_UP: begin
				// Every cell at or below the removed position takes its lower neighbor.
				if (MY_IDX >= from) begin
					val_q   <= below_val;
					stamp_q <= below_stamp;
				end
			end
			default: begin
			end
		endcase
	end

	assign val   = val_q;
	assign stamp = stamp_q;
	assign hit   = (val_q == key);

endmodule

>>> design/tsws_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_chain: row of entry cells
// Cell 0 is the top of the stack; each cell hands its entry to the neighbor
// below on a push and takes the one below when an entry above it goes away.
// ----------------------------------------------------------------------------
module tsws_chain #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                                      clk,
	input  tsws_pkg::cell_ctl_t                       ctl,
	input  logic [IDX_W-1:0]                          from,
	input  logic [tsws_pkg::DATA_W-1:0]               key,
	output logic [DEPTH-1:0][tsws_pkg::DATA_W-1:0]    vals,
	output logic [DEPTH-1:0][tsws_pkg::DATA_W-1:0]    stamps,
	output logic [DEPTH-1:0]                          hits
);
	import tsws_pkg::*;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] above_val;
		logic [DATA_W-1:0] above_stamp;
		logic [DATA_W-1:0] below_val;
		logic [DATA_W-1:0] below_stamp;

		if (i == 0) begin : g_top
			assign above_val   = ctl.val;
			assign above_stamp = ctl.stamp;
		end else begin : g_mid
			assign above_val   = vals[i-1];
			assign above_stamp = stamps[i-1];
		end

		if (i == DEPTH - 1) begin : g_bottom
			assign below_val   = '0;
			assign below_stamp = '0;
		end else begin : g_upper
			assign below_val   = vals[i+1];
			assign below_stamp = stamps[i+1];
		end

		tsws_cell #(
			.CELL_IDX (i),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.from        (from),
			.key         (key),
			.above_val   (above_val),
			.above_stamp (above_stamp),
			.below_val   (below_val),
			.below_stamp (below_stamp),
			.val         (vals[i]),
			.stamp       (stamps[i]),
			.hit         (hits[i])
		);
	end

endmodule

>>> design/tagged_stack_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_stack_with_search_core: bounded LIFO of (value, timestamp) entries
// Push, pop, remove at position, search and duplicate removal over a row of
// entry cells with a small controller.
// ----------------------------------------------------------------------------
// The stack lives in a row of DEPTH cells, cell 0 being the top. Push, pop,
// remove and search each finish in the cycle in which the request transfer
// happens, so these requests can be taken one per cycle while the result
// channel keeps up. A dedup request then enters a sequencer that walks the
// kept entries from the top and removes deeper repeats one at a time; no
// request is taken during that walk. The result sits in an output register,
// and a new request is taken in the same cycle in which the previous result
// is transferred. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module tagged_stack_with_search_core #(
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	tsws_req_if.sink     req,
	tsws_rsp_if.source   rsp
);
	import tsws_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	ctrl_state_e state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [DATA_W-1:0] key_q, key_d;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_valid_q;
	logic              rsp_load;

	cell_ctl_t                     ctl;
	logic [IDX_W-1:0]              from;
	logic [DATA_W-1:0]             key;
	logic [DEPTH-1:0][DATA_W-1:0]  vals;
	logic [DEPTH-1:0][DATA_W-1:0]  stamps;
	logic [DEPTH-1:0]              hits;
	logic [DEPTH-1:0]              live;
	logic [DEPTH-1:0]              hits_live;
	logic                          any_hit;
	logic [IDX_W-1:0]              first_idx;
	logic [IDX_W-1:0]              rd_idx;
	logic [DATA_W-1:0]             rd_val;
	logic [DATA_W-1:0]             rd_stamp;
	logic                          in_xfer;
	logic                          dedup_done;

	function automatic logic [IDX_W-1:0] find_first(input logic [DEPTH-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

	tsws_chain #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_chain (
		.clk    (clk),
		.ctl    (ctl),
		.from   (from),
		.key    (key),
		.vals   (vals),
		.stamps (stamps),
		.hits   (hits)
	);

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign in_xfer   = req.valid && req.ready;

	// During dedup the key is the entry being kept; otherwise the search value.
	assign key = (state_q == S_DEDUP) ? key_q : req.data.search_value;

	// Only held entries take part; during dedup only those below the kept one.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			live[i] = (CNT_W'(i) < count_q) &&
				((state_q != S_DEDUP) || (IDX_W'(i) > k_q));
		end
	end

	assign hits_live = hits & live;
	assign any_hit   = |hits_live;
	assign first_idx = find_first(hits_live);

	assign rd_idx   = (state_q == S_DEDUP) ? IDX_W'(k_q + 1'b1) : first_idx;
	assign rd_val   = vals[rd_idx];
	assign rd_stamp = stamps[rd_idx];

	assign dedup_done = (CNT_W'(CNT_W'(k_q) + 1'b1) >= count_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && (req_e'(req.data.req_type) == REQ_DEDUP)) begin
					state_d = S_DEDUP;
				end
			end
			S_DEDUP: begin
				if (dedup_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the controller
	always_comb begin
		ctl.cmd   = CMD_HOLD;
		ctl.val   = req.data.push_value;
		ctl.stamp = req.data.push_time;
		from      = '0;
		count_d   = count_q;
		k_d       = k_q;
		key_d     = key_q;
		rsp_load  = 1'b0;
		rsp_d     = '0;

		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					rsp_load = 1'b1;
					case (req_e'(req.data.req_type))
						REQ_PUSH: begin
							if (count_q == FULL_CNT) begin
								rsp_d.status = STS_FULL;
							end else begin
								ctl.cmd = CMD_PUSH;
								count_d = CNT_W'(count_q + 1'b1);
							end
						end
						REQ_POP: begin
							if (count_q == '0) begin
								rsp_d.status = STS_EMPTY;
							end else begin
								ctl.cmd         = CMD_SHIFT_UP;
								count_d         = CNT_W'(count_q - 1'b1);
								rsp_d.out_value = vals[0];
								rsp_d.out_time  = stamps[0];
							end
						end
						REQ_REMOVE: begin
							if (32'(req.data.remove_position) >= 32'(count_q)) begin
								rsp_d.status = STS_RANGE;
							end else begin
								ctl.cmd = CMD_SHIFT_UP;
								from    = IDX_W'(req.data.remove_position);
								count_d = CNT_W'(count_q - 1'b1);
							end
						end
						REQ_SEARCH: begin
							if (any_hit) begin
								rsp_d.out_value      = rd_val;
								rsp_d.out_time       = rd_stamp;
								rsp_d.found_position = 4'(first_idx);
							end else begin
								rsp_d.status = STS_NOT_FOUND;
							end
						end
						REQ_DEDUP: begin
							rsp_load = 1'b0;
							k_d      = '0;
							key_d    = vals[0];
						end
						default: begin
						end
					endcase
					rsp_d.entry_count = 5'(count_d);
				end
			end
			S_DEDUP: begin
				if (dedup_done) begin
					rsp_load          = 1'b1;
					rsp_d.entry_count = 5'(count_q);
				end else if (any_hit) begin
					// Drop the nearest repeat of the kept value; the kept entry stays.
					ctl.cmd = CMD_SHIFT_UP;
					from    = first_idx;
					count_d = CNT_W'(count_q - 1'b1);
				end else begin
					k_d   = IDX_W'(k_q + 1'b1);
					key_d = rd_val;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond capacity");

	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_DEDUP) || rsp_valid_q)
		else $error("request transfer left neither a result nor a dedup walk");

	a_dedup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEDUP) |-> !rsp_valid_q && !req.ready)
		else $error("channel activity during the dedup walk");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == CMD_PUSH) |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("push did not grow the stack by one");

	a_dedup_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEDUP) |=> count_q <= $past(count_q))
		else $error("dedup walk grew the stack");

endmodule
